@@ src/shp_pkg.sv @@
package shp_pkg;

  localparam int ID_W   = 10;
  localparam int TIME_W = 40;
  localparam int RES_W  = TIME_W + 1;

  // Hits returned per input signal; later pairs are dropped.
  localparam int MAX_HITS = 15;
  localparam int HIT_CNT_W = 4;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 96;

  typedef struct packed {
    logic [TIME_W-1:0] sig_time;
    logic              side;
    logic [ID_W-1:0]   id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [RES_W-1:0] time_sum;
    logic [RES_W-1:0] time_diff;
    logic [ID_W-1:0]  scin;
  } hit_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

@@ src/shp_ram.sv @@
module shp_ram #(
  parameter int WIDTH = 51,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/shp_pair_unit.sv @@
module shp_pair_unit (
  input  shp_pkg::entry_t cur,
  input  shp_pkg::entry_t stored,
  output logic            match,
  output shp_pkg::hit_t   hit
);

  import shp_pkg::*;

  logic [RES_W-1:0] time_a;
  logic [RES_W-1:0] time_b;

  // A stored signal pairs only with the opposite side of the same strip.
  assign match = (stored.id == cur.id) && (stored.side != cur.side);

  always_comb begin
    if (!cur.side) begin
      time_a = {1'b0, cur.sig_time};
      time_b = {1'b0, stored.sig_time};
    end else begin
      time_a = {1'b0, stored.sig_time};
      time_b = {1'b0, cur.sig_time};
    end
    hit.scin      = cur.id;
    hit.time_diff = time_a - time_b;
    hit.time_sum  = time_a + time_b;
  end

endmodule

@@ src/scintillator_hit_pairing_core.sv @@
// Double-ended scintillator hit pairing. Each photomultiplier signal request
// on the input carries a strip id, a side and a 40-bit time, and in_tuser
// opens a new time window, clearing the window store before the signal is
// compared. The signal is checked against every signal stored in its window,
// one stored entry per clock while the output does not stall, through a
// single shared compare/add/subtract unit, and each stored signal of the same
// strip on the opposite side yields one hit request on the output, in the
// order the stored signals arrived. A hit gives the strip id, side-A time
// minus side-B time (two's complement) and the sum of both times; out_tlast
// marks the last hit of an input signal. At most 15 hits are returned per
// signal; further pairs are dropped. The signal is stored on acceptance,
// past the entries it is compared against, if the window holds fewer than
// WINDOW_DEPTH entries. A signal that finds an empty window is taken without
// a scan; otherwise the block is busy while it scans the stored entries
// (fewer once the hit limit is reached), as the window memory has one read
// port: one entry per cycle, unless a hit waits behind a stalled output.
module scintillator_hit_pairing_core #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, from bit 0: scin_id[9:0], pm_side, signal_time[39:0], zero pad.
  input  logic [55:0] in_tdata,
  // in_tuser: window_start.
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata, from bit 0: hit_scin[9:0], time_diff[40:0], time_sum[40:0],
  // zero pad.
  output logic [95:0] out_tdata,
  // out_tlast: last_hit.
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready
);

  import shp_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    lim_r, lim_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic [HIT_CNT_W-1:0] hits_r, hits_nxt;
  logic             dvalid_r, dvalid_nxt;
  logic             pend_v_r, pend_v_nxt;
  hit_t             pend_r, pend_nxt;
  logic             out_v_r, out_v_nxt;
  hit_t             out_r, out_nxt;
  logic             out_last_r, out_last_nxt;
  entry_t           cur_r, cur_nxt;

  entry_t           in_entry;
  entry_t           rd_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic             unit_match;
  hit_t             unit_hit;

  logic             in_acc;
  logic [CW-1:0]    count_eff;
  logic             wr_en;
  logic             push_ok;
  logic             match;
  logic             stall;
  logic [HIT_CNT_W:0] hits_after;
  logic             issue;
  logic             scan_end;
  logic             done;
  logic             push;

  assign in_entry.id       = in_tdata[ID_W-1:0];
  assign in_entry.side     = in_tdata[ID_W];
  assign in_entry.sig_time = in_tdata[ID_W+TIME_W:ID_W+1];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // A window start empties the store before this signal is compared.
  assign count_eff = in_tuser ? '0 : count_r;
  assign wr_en     = in_acc && (count_eff < CW'(WINDOW_DEPTH));

  shp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_eff[AW-1:0]),
    .wr_data(in_entry),
    .rd_en  (issue),
    .rd_addr(k_r[AW-1:0]),
    .rd_data(rd_data)
  );

  assign rd_entry = rd_data;

  shp_pair_unit u_pair (
    .cur   (cur_r),
    .stored(rd_entry),
    .match (unit_match),
    .hit   (unit_hit)
  );

  // A hit is held back in a pending register so that its last flag is known
  // when it moves to the output register.
  assign push_ok    = !out_v_r || out_tready;
  assign match      = (state_r == ST_SCAN) && dvalid_r && unit_match;
  assign stall      = match && pend_v_r && !push_ok;
  assign hits_after = {1'b0, hits_r} + {{HIT_CNT_W{1'b0}}, match};
  assign issue      = (state_r == ST_SCAN) && !stall && (k_r < lim_r) &&
                      (hits_after < (HIT_CNT_W+1)'(MAX_HITS));
  assign scan_end   = (state_r == ST_SCAN) && !dvalid_r && !issue;
  assign done       = scan_end && (!pend_v_r || push_ok);
  assign push       = pend_v_r && push_ok && (match || scan_end);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (count_eff != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt    = count_r;
    lim_nxt      = lim_r;
    k_nxt        = k_r;
    hits_nxt     = hits_r;
    dvalid_nxt   = dvalid_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    cur_nxt      = cur_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    out_v_nxt    = out_v_r && !out_tready;

    if (in_acc) begin
      cur_nxt    = in_entry;
      lim_nxt    = count_eff;
      count_nxt  = wr_en ? count_eff + CW'(1) : count_eff;
      k_nxt      = '0;
      hits_nxt   = '0;
      dvalid_nxt = 1'b0;
      pend_v_nxt = 1'b0;
    end

    if ((state_r == ST_SCAN) && !stall) begin
      dvalid_nxt = issue;
      if (issue) begin
        k_nxt = k_r + CW'(1);
      end
      if (match) begin
        pend_nxt   = unit_hit;
        pend_v_nxt = 1'b1;
        hits_nxt   = hits_after[HIT_CNT_W-1:0];
      end
    end

    if (push) begin
      out_nxt      = pend_r;
      out_last_nxt = scan_end;
      out_v_nxt    = 1'b1;
    end

    if (done) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      lim_r    <= '0;
      k_r      <= '0;
      hits_r   <= '0;
      dvalid_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      lim_r    <= lim_nxt;
      k_r      <= k_nxt;
      hits_r   <= hits_nxt;
      dvalid_r <= dvalid_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(hit_t)){1'b0}}, out_r};

endmodule
